// File: rtl/thc_pkg.sv
// Shared types and constants for the temperature / humidity compensation block.
// No dependencies; every other file in rtl/ imports this package.
package thc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic        [19:0] raw_temp_t;
    typedef logic        [15:0] raw_hum_t;
    typedef logic signed [22:0] fine_temp_t;
    typedef logic signed [15:0] temp_centi_t;
    typedef logic        [16:0] hum_q10_t;
    typedef logic signed [31:0] word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_ONE     = 3'd0,
        CFG_TEMP_TWO     = 3'd1,
        CFG_TEMP_THREE   = 3'd2,
        CFG_HUM_ONE      = 3'd3,
        CFG_HUM_TWO      = 3'd4,
        CFG_HUM_THREE    = 3'd5,
        CFG_HUM_FOUR_FIVE = 3'd6,
        CFG_HUM_SIX      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } coef_t;

    localparam word_t CENTI_ROUND  = 32'sd128;
    localparam word_t HUM_T_OFFSET = 32'sd76800;
    localparam word_t HUM_A_ROUND  = 32'sd16384;
    localparam word_t HUM_R_OFFSET = 32'sd32768;
    localparam word_t HUM_B_OFFSET = 32'sd2097152;
    localparam word_t HUM_B_ROUND  = 32'sd8192;
    localparam word_t HUM_LIMIT    = 32'sd419430400;

    localparam word_t FINE_MAX  = 32'sd4194303;
    localparam word_t FINE_MIN  = -32'sd4194304;
    localparam word_t CENTI_MAX = 32'sd32767;
    localparam word_t CENTI_MIN = -32'sd32768;

    localparam hum_q10_t HUM_Q10_MAX = 17'd102400;

    // (fine * 5 + 128) >>> 8, saturated to 16 bits signed
    function automatic temp_centi_t centi_of(input word_t fine);
        word_t t;
        t = ((fine <<< 2) + fine + CENTI_ROUND) >>> 8;
        if (t > CENTI_MAX)
            return temp_centi_t'(CENTI_MAX);
        else if (t < CENTI_MIN)
            return temp_centi_t'(CENTI_MIN);
        else
            return t[15:0];
    endfunction

endpackage

// File: rtl/thc_if.sv
// Valid/ready channels for raw sample items and compensated result items.
// Depends on thc_pkg for the field types.
interface thc_in_if import thc_pkg::*; ();
    logic      valid;
    logic      ready;
    raw_temp_t raw_temp;
    raw_hum_t  raw_hum;

    modport source (output valid, raw_temp, raw_hum, input ready);
    modport sink   (input valid, raw_temp, raw_hum, output ready);
endinterface

interface thc_out_if import thc_pkg::*; ();
    logic        valid;
    logic        ready;
    fine_temp_t  fine_temp;
    temp_centi_t temp_centi;
    hum_q10_t    hum_q10;

    modport source (output valid, fine_temp, temp_centi, hum_q10, input ready);
    modport sink   (input valid, fine_temp, temp_centi, hum_q10, output ready);
endinterface

// File: rtl/temp_humidity_compensation_top.sv
// Temperature / humidity compensation, 32-bit integer scheme, 16 register stages.
// One item per cycle sustained while result_out.ready stays high. Each stage holds up to
// three multiplies (stage 6) or a short add/compare; stages stall independently, so bubbles
// are squeezed out; input is taken while a result waits at the output if a stage is empty.
// Reset (rst_n low, async) clears all stage valid bits and all coefficients to zero.
// Depends on thc_pkg, thc_if and thc_cfg_regs.
module temp_humidity_compensation_top import thc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    thc_in_if.sink                sample_in,
    thc_out_if.source             result_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NSTG = 16;

    coef_t coef;

    thc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .coef  (coef)
    );

    // sign/zero extended coefficients
    word_t t2_w, t3_w, h1_w, h2_w, h3_w, h5_w, h6_w;

    assign t2_w = signed'({{16{coef.t2[15]}}, coef.t2});
    assign t3_w = signed'({{16{coef.t3[15]}}, coef.t3});
    assign h1_w = signed'({24'd0, coef.h1});
    assign h2_w = signed'({{16{coef.h2[15]}}, coef.h2});
    assign h3_w = signed'({24'd0, coef.h3});
    assign h5_w = signed'({{20{coef.h5[11]}}, coef.h5});
    assign h6_w = signed'({{24{coef.h6[7]}}, coef.h6});

    // ---------------- stage control ----------------
    logic [NSTG:1] v_reg;
    logic [NSTG:1] en;

    always_comb
    begin
        en[NSTG] = !v_reg[NSTG] || result_out.ready;
        for (int k = NSTG - 1; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
                v_reg[1] <= sample_in.valid;
            for (int k = 2; k <= NSTG; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    assign sample_in.ready = en[1];

    // ---------------- datapath ----------------
    function automatic fine_temp_t fine_sat(input word_t v);
        if (v > FINE_MAX)
            return fine_temp_t'(FINE_MAX);
        else if (v < FINE_MIN)
            return fine_temp_t'(FINE_MIN);
        else
            return v[22:0];
    endfunction

    function automatic hum_q10_t hum_clamp(input word_t v);
        word_t lim;
        lim = (v < 0) ? '0 : ((v > HUM_LIMIT) ? HUM_LIMIT : v);
        return lim[28:12];
    endfunction

    function automatic temp_centi_t centi_sat(input word_t t);
        if (t > CENTI_MAX)
            return temp_centi_t'(CENTI_MAX);
        else if (t < CENTI_MIN)
            return temp_centi_t'(CENTI_MIN);
        else
            return t[15:0];
    endfunction

    raw_hum_t    hraw_reg  [1:4];
    word_t       ta_reg, d_reg;
    word_t       p1_reg, p2_reg;
    word_t       var1_reg, p3_reg;
    word_t       fine_reg;
    word_t       c5_reg, x5_reg, hbase_reg;
    word_t       mh6_reg, mh3_reg, mh5_reg, hbase6_reg;
    word_t       q7_reg, r7_reg;
    word_t       a_reg     [7:11];
    word_t       bb8_reg, b9_reg, m10_reg, b11_reg;
    word_t       x_reg     [12:15];
    word_t       c13_reg, cc14_reg, e15_reg;
    fine_temp_t  fsat_reg  [5:16];
    temp_centi_t centi_reg [6:16];
    hum_q10_t    hum_reg;

    always_ff @(posedge clk)
    begin
        // stage 1: temperature differences and raw humidity capture
        if (en[1])
        begin
            ta_reg      <= signed'({15'd0, sample_in.raw_temp[19:3]})
                         - signed'({15'd0, coef.t1, 1'b0});
            d_reg       <= signed'({16'd0, sample_in.raw_temp[19:4]})
                         - signed'({16'd0, coef.t1});
            hraw_reg[1] <= sample_in.raw_hum;
        end
        for (int k = 2; k <= 4; k++)
            if (en[k])
                hraw_reg[k] <= hraw_reg[k-1];

        if (en[2])
        begin
            p1_reg <= ta_reg * t2_w;
            p2_reg <= d_reg * d_reg;
        end

        if (en[3])
        begin
            var1_reg <= p1_reg >>> 11;
            p3_reg   <= (p2_reg >>> 12) * t3_w;
        end

        if (en[4])
            fine_reg <= var1_reg + (p3_reg >>> 14);

        // stage 5: centi pre-sum, fine saturation, humidity offset and base term
        if (en[5])
        begin
            c5_reg      <= (fine_reg <<< 2) + fine_reg + CENTI_ROUND;
            x5_reg      <= fine_reg - HUM_T_OFFSET;
            fsat_reg[5] <= fine_sat(fine_reg);
            hbase_reg   <= signed'({2'b00, hraw_reg[4], 14'd0})
                         - signed'({coef.h4, 20'd0}) + HUM_A_ROUND;
        end

        if (en[6])
        begin
            centi_reg[6] <= centi_sat(c5_reg >>> 8);
            mh6_reg      <= x5_reg * h6_w;
            mh3_reg      <= x5_reg * h3_w;
            mh5_reg      <= x5_reg * h5_w;
            hbase6_reg   <= hbase_reg;
        end

        if (en[7])
        begin
            q7_reg   <= mh6_reg >>> 10;
            r7_reg   <= (mh3_reg >>> 11) + HUM_R_OFFSET;
            a_reg[7] <= (hbase6_reg - mh5_reg) >>> 15;
        end
        for (int k = 8; k <= 11; k++)
            if (en[k])
                a_reg[k] <= a_reg[k-1];

        if (en[8])
            bb8_reg <= q7_reg * r7_reg;
        if (en[9])
            b9_reg <= (bb8_reg >>> 10) + HUM_B_OFFSET;
        if (en[10])
            m10_reg <= b9_reg * h2_w;
        if (en[11])
            b11_reg <= (m10_reg + HUM_B_ROUND) >>> 14;
        if (en[12])
            x_reg[12] <= a_reg[11] * b11_reg;
        for (int k = 13; k <= 15; k++)
            if (en[k])
                x_reg[k] <= x_reg[k-1];

        // stages 13..15: square correction term
        if (en[13])
            c13_reg <= x_reg[12] >>> 15;
        if (en[14])
            cc14_reg <= c13_reg * c13_reg;
        if (en[15])
            e15_reg <= (cc14_reg >>> 7) * h1_w;

        // stage 16: humidity clamp into the output register
        if (en[16])
            hum_reg <= hum_clamp(x_reg[15] - (e15_reg >>> 4));

        for (int k = 6; k <= 16; k++)
            if (en[k])
                fsat_reg[k] <= fsat_reg[k-1];
        for (int k = 7; k <= 16; k++)
            if (en[k])
                centi_reg[k] <= centi_reg[k-1];
    end

    assign result_out.valid      = v_reg[NSTG];
    assign result_out.fine_temp  = fsat_reg[16];
    assign result_out.temp_centi = centi_reg[16];
    assign result_out.hum_q10    = hum_reg;

endmodule

// File: rtl/thc_cfg_regs.sv
// Calibration coefficient registers with a plain indexed write port.
// Depends on thc_pkg (coef_t, cfg_index_t).
module thc_cfg_regs import thc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [CFG_IDX_W-1:0]  index,
    input  logic [CFG_DATA_W-1:0] data,
    output coef_t                 coef
);

    coef_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (we)
        begin
            unique case (cfg_index_t'(index))
                CFG_TEMP_ONE:      coef_reg.t1 <= data[15:0];
                CFG_TEMP_TWO:      coef_reg.t2 <= data[15:0];
                CFG_TEMP_THREE:    coef_reg.t3 <= data[15:0];
                CFG_HUM_ONE:       coef_reg.h1 <= data[7:0];
                CFG_HUM_TWO:       coef_reg.h2 <= data[15:0];
                CFG_HUM_THREE:     coef_reg.h3 <= data[7:0];
                CFG_HUM_FOUR_FIVE:
                begin
                    coef_reg.h4 <= data[23:12];
                    coef_reg.h5 <= data[11:0];
                end
                CFG_HUM_SIX:       coef_reg.h6 <= data[7:0];
                default: ;
            endcase
        end
    end

    assign coef = coef_reg;

endmodule

// File: rtl/thc_checker.sv
// Port-level checks for temp_humidity_compensation_top, attached by bind.
// Depends on thc_pkg (field types, limits, centi_of).
module thc_checker import thc_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input fine_temp_t  fine_temp,
    input temp_centi_t temp_centi,
    input hum_q10_t    hum_q10
);

    // a result never leaves the clamped humidity range
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hum_q10 <= HUM_Q10_MAX))
        else $error("hum_q10 above clamp limit");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(fine_temp) && $stable(temp_centi) && $stable(hum_q10)))
        else $error("stalled result changed");

    // with the output stage empty nothing can hold the pipe back
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // unsaturated fine temperature determines the centi value
    a_centi_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (fine_temp != fine_temp_t'(FINE_MAX))
                   && (fine_temp != fine_temp_t'(FINE_MIN)))
            |-> (temp_centi == centi_of(signed'({{9{fine_temp[22]}}, fine_temp}))))
        else $error("temp_centi inconsistent with fine_temp");

endmodule

bind temp_humidity_compensation_top thc_checker u_thc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (sample_in.ready),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .fine_temp  (result_out.fine_temp),
    .temp_centi (result_out.temp_centi),
    .hum_q10    (result_out.hum_q10)
);
